### rtl/xpbm_pkg.sv
// Shared types and constants for the PORTB bank mapper.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none

package xpbm_pkg;

  localparam int unsigned PortW   = 8;
  localparam int unsigned BankW   = 7;
  localparam int unsigned OpW     = 3;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 8;

  typedef enum logic [OpW-1:0] {
    OP_PORTB_WR  = 3'd0,
    OP_CART8_ON  = 3'd1,
    OP_CART8_OFF = 3'd2,
    OP_CARTA_ON  = 3'd3,
    OP_CARTA_OFF = 3'd4
  } opcode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MACHINE_CLASS = 2'd0,
    CFG_RAM_KIND      = 2'd1
  } cfg_index_e;

  typedef enum logic [1:0] {
    CLASS_800  = 2'd0,
    CLASS_5200 = 2'd1,
    CLASS_XLXE = 2'd2
  } machine_class_e;

  // Ordered by size, so magnitude compares on the code are size compares.
  typedef enum logic [2:0] {
    RAM_16K   = 3'd0,
    RAM_48K   = 3'd1,
    RAM_64K   = 3'd2,
    RAM_128K  = 3'd3,
    RAM_320K  = 3'd4,
    RAM_576K  = 3'd5,
    RAM_1M    = 3'd6
  } ram_size_e;

  typedef enum logic [1:0] {
    ANTIC_SAME = 2'd0,
    ANTIC_BASE = 2'd1,
    ANTIC_EXT  = 2'd2
  } antic_mode_e;

  typedef enum logic [1:0] {
    OS_RAM     = 2'd0,
    OS_ROM     = 2'd1,
    OS_OPENBUS = 2'd2
  } os_area_e;

  typedef enum logic [1:0] {
    A000_RAM   = 2'd0,
    A000_BASIC = 2'd1,
    A000_CART  = 2'd2
  } a000_area_e;

  // Effective configuration after folding out-of-range codes.
  typedef struct packed {
    machine_class_e cls;
    ram_size_e      ram;
  } xpbm_cfg_t;

  // Declared MSB first, so cpu_bank lands in the lowest bits.
  typedef struct packed {
    logic        trig_three;
    logic        cart_8000_on;
    logic        selftest_on;
    a000_area_e  a000_area;
    os_area_e    os_area;
    logic [BankW-1:0] antic_bank;
    antic_mode_e antic_mode;
    logic [BankW-1:0] cpu_bank;
  } xpbm_result_t;

  localparam int unsigned ResultW = $bits(xpbm_result_t);
  localparam int unsigned OutDataW = ((ResultW + 7) / 8) * 8;

endpackage

`default_nettype wire

### rtl/xpbm_cfg_regs.sv
// Configuration registers of the PORTB bank mapper and their decode into an
// effective machine class and RAM size. Depends on xpbm_pkg.
`default_nettype none

module xpbm_cfg_regs import xpbm_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [CfgDatW-1:0] cfg_data_i,
  output xpbm_cfg_t               cfg_o
);

  logic [1:0] machine_class_q, machine_class_d;
  logic [2:0] ram_kind_q, ram_kind_d;

  always_comb begin
    machine_class_d = machine_class_q;
    ram_kind_d      = ram_kind_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MACHINE_CLASS: machine_class_d = cfg_data_i[1:0];
        CFG_RAM_KIND:      ram_kind_d      = cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      machine_class_q <= CLASS_XLXE;
      ram_kind_q      <= 3'd1;
    end else begin
      machine_class_q <= machine_class_d;
      ram_kind_q      <= ram_kind_d;
    end
  end

  // Class three behaves as XL/XE; RAM kinds five to seven behave as 1088K.
  always_comb begin
    unique case (machine_class_q)
      2'd0:    cfg_o.cls = CLASS_800;
      2'd1:    cfg_o.cls = CLASS_5200;
      default: cfg_o.cls = CLASS_XLXE;
    endcase
    if (cfg_o.cls == CLASS_800) begin
      cfg_o.ram = RAM_48K;
    end else if (cfg_o.cls == CLASS_5200) begin
      cfg_o.ram = RAM_16K;
    end else begin
      unique case (ram_kind_q)
        3'd0:    cfg_o.ram = RAM_48K;
        3'd1:    cfg_o.ram = RAM_64K;
        3'd2:    cfg_o.ram = RAM_128K;
        3'd3:    cfg_o.ram = RAM_320K;
        3'd4:    cfg_o.ram = RAM_576K;
        default: cfg_o.ram = RAM_1M;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/xpbm_map_state.sv
// Mapping state of the PORTB bank mapper: applies one command per beat and
// forms the region map from the updated state. Depends on xpbm_pkg.
`default_nettype none

module xpbm_map_state import xpbm_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire xpbm_cfg_t        cfg_i,
  input  wire logic             cmd_fire_i,
  input  wire logic [OpW-1:0]   opcode_i,
  input  wire logic [PortW-1:0] port_value_i,
  output xpbm_result_t          result_o
);

  logic [PortW-1:0] last_port_q, last_port_d;
  logic [BankW-1:0] cur_bank_q, cur_bank_d;
  antic_mode_e      antic_sel_q, antic_sel_d;
  logic [BankW-1:0] antic_ext_q, antic_ext_d;
  logic             os_en_q, os_en_d;
  logic             selftest_q, selftest_d;
  logic             cart_low_q, cart_low_d;
  logic             cart_high_q, cart_high_d;
  logic             trig_q, trig_d;

  logic [5:0]       bank_idx;
  logic [BankW-1:0] bank_ext;
  logic [BankW-1:0] bank_new;
  logic             is_576;
  logic [PortW-1:0] pb;

  assign pb     = port_value_i;
  assign is_576 = (cfg_i.ram == RAM_576K);

  // Extended bank index as laid out by each expansion's PORTB bits.
  always_comb begin
    unique case (cfg_i.ram)
      RAM_128K: bank_idx = {4'b0, pb[3:2]};
      RAM_320K: bank_idx = {2'b0, pb[6:5], pb[3:2]};
      RAM_576K: bank_idx = {1'b0, pb[7:6], pb[3:1]};
      default:  bank_idx = {pb[7:5], pb[3:1]};
    endcase
    bank_ext = {1'b0, bank_idx} + BankW'(1);
    bank_new = pb[4] ? '0 : bank_ext;
  end

  always_comb begin
    last_port_d = last_port_q;
    cur_bank_d  = cur_bank_q;
    antic_sel_d = antic_sel_q;
    antic_ext_d = antic_ext_q;
    os_en_d     = os_en_q;
    selftest_d  = selftest_q;
    cart_low_d  = cart_low_q;
    cart_high_d = cart_high_q;
    trig_d      = trig_q;

    if (cmd_fire_i) begin
      case (opcode_i)
        OP_PORTB_WR: begin
          if (cfg_i.cls != CLASS_800) begin
            if (cfg_i.ram > RAM_64K) begin
              if (selftest_d && (bank_new != cur_bank_q || (is_576 && !pb[5]))) begin
                selftest_d = 1'b0;
              end
              cur_bank_d = bank_new;
              if (cfg_i.ram == RAM_128K || is_576) begin
                case (pb[5:4])
                  2'b10: antic_sel_d = ANTIC_BASE;
                  2'b01: begin
                    antic_sel_d = ANTIC_EXT;
                    antic_ext_d = bank_ext;
                  end
                  default: antic_sel_d = ANTIC_SAME;
                endcase
              end
            end
            // The OS ROM only follows bit 0 when that bit actually changes.
            if (last_port_q[0] != pb[0]) begin
              os_en_d = pb[0];
              if (!pb[0]) begin
                selftest_d = 1'b0;
              end
            end
            if (cfg_i.cls == CLASS_XLXE) begin
              if (pb[7] || (is_576 && !pb[5])) begin
                selftest_d = 1'b0;
              end else if (!selftest_d && pb[0]
                           && !(pb[5:4] != 2'b11 && is_576)
                           && !(!pb[4] && cfg_i.ram == RAM_1M)) begin
                selftest_d = 1'b1;
              end
            end
            last_port_d = pb;
          end
        end
        OP_CART8_ON:  cart_low_d = 1'b1;
        OP_CART8_OFF: cart_low_d = 1'b0;
        OP_CARTA_ON: begin
          if (!cart_high_q) begin
            cart_high_d = 1'b1;
            if (cfg_i.cls == CLASS_XLXE) trig_d = 1'b1;
          end
        end
        OP_CARTA_OFF: begin
          if (cart_high_q) begin
            cart_high_d = 1'b0;
            if (cfg_i.cls == CLASS_XLXE) trig_d = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_port_q <= '1;
      cur_bank_q  <= '0;
      antic_sel_q <= ANTIC_SAME;
      antic_ext_q <= BankW'(1);
      os_en_q     <= 1'b1;
      selftest_q  <= 1'b0;
      cart_low_q  <= 1'b0;
      cart_high_q <= 1'b0;
      trig_q      <= 1'b0;
    end else begin
      last_port_q <= last_port_d;
      cur_bank_q  <= cur_bank_d;
      antic_sel_q <= antic_sel_d;
      antic_ext_q <= antic_ext_d;
      os_en_q     <= os_en_d;
      selftest_q  <= selftest_d;
      cart_low_q  <= cart_low_d;
      cart_high_q <= cart_high_d;
      trig_q      <= trig_d;
    end
  end

  // Region map, taken from the state as it stands after this command.
  always_comb begin
    result_o.cpu_bank   = cur_bank_d;
    result_o.antic_mode = antic_sel_d;
    result_o.antic_bank = (antic_sel_d == ANTIC_EXT) ? antic_ext_d : BankW'(1);
    if (os_en_d) begin
      result_o.os_area = OS_ROM;
    end else if (cfg_i.ram > RAM_48K) begin
      result_o.os_area = OS_RAM;
    end else begin
      result_o.os_area = OS_OPENBUS;
    end
    if (cart_high_d) begin
      result_o.a000_area = A000_CART;
    end else if (cfg_i.cls == CLASS_XLXE && !last_port_d[1]
                 && !(!last_port_d[4] && cfg_i.ram >= RAM_576K)) begin
      result_o.a000_area = A000_BASIC;
    end else begin
      result_o.a000_area = A000_RAM;
    end
    result_o.selftest_on  = selftest_d;
    result_o.cart_8000_on = cart_low_d;
    result_o.trig_three   = trig_d;
  end

endmodule

`default_nettype wire

### rtl/xpbm_out_buf.sv
// Two-entry result buffer (output register plus skid stage) between the
// mapping logic and the result stream. Depends on xpbm_pkg.
`default_nettype none

module xpbm_out_buf import xpbm_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   in_valid_i,
  output logic        in_ready_o,
  input  wire xpbm_result_t in_data_i,
  output logic        out_valid_o,
  input  wire logic   out_ready_i,
  output xpbm_result_t out_data_o
);

  logic         main_v_q, main_v_d;
  logic         skid_v_q, skid_v_d;
  xpbm_result_t main_q, skid_q;
  logic         load_main_in, load_main_skid, load_skid;
  logic         in_fire, out_fire;

  assign in_ready_o  = !skid_v_q;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = main_v_q && out_ready_i;
  assign out_valid_o = main_v_q;
  assign out_data_o  = main_q;

  always_comb begin
    main_v_d       = main_v_q;
    skid_v_d       = skid_v_q;
    load_main_in   = 1'b0;
    load_main_skid = 1'b0;
    load_skid      = 1'b0;
    if (out_fire) begin
      if (skid_v_q) begin
        load_main_skid = 1'b1;
        skid_v_d       = 1'b0;
      end else if (in_fire) begin
        load_main_in = 1'b1;
      end else begin
        main_v_d = 1'b0;
      end
    end else if (in_fire) begin
      if (!main_v_q) begin
        load_main_in = 1'b1;
        main_v_d     = 1'b1;
      end else begin
        load_skid = 1'b1;
        skid_v_d  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      main_v_q <= main_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_main_in) begin
      main_q <= in_data_i;
    end else if (load_main_skid) begin
      main_q <= skid_q;
    end
    if (load_skid) begin
      skid_q <= in_data_i;
    end
  end

endmodule

`default_nettype wire

### rtl/xe_portb_bank_mapper.sv
// Top level of the PORTB bank mapper; instantiates xpbm_cfg_regs,
// xpbm_map_state and xpbm_out_buf, and imports xpbm_pkg.
// The result of an accepted command is registered into the output buffer at
// the accepting edge. One command per cycle while the buffer has room.
// Reset (rst_ni low, asynchronous) restores the power-on mapping state and
// configuration and empties the result buffer.
`default_nettype none

module xe_portb_bank_mapper import xpbm_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Command stream.
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [PortW-1:0]    s_axis_tdata,   // [7:0] port_value
  input  wire logic [OpW-1:0]      s_axis_tuser,   // [2:0] opcode
  // Result stream.
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // [6:0] cpu_bank, [8:7] antic_mode, [15:9] antic_bank, [17:16] os_area,
  // [19:18] a000_area, [20] selftest_on, [21] cart_8000_on, [22] trig_three,
  // [23] zero
  output logic [OutDataW-1:0]      m_axis_tdata,
  // Configuration write channel.
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDatW-1:0]  cfg_data_i
);

  xpbm_cfg_t    cfg;
  xpbm_result_t map_result;
  xpbm_result_t out_result;
  logic         cmd_fire;

  // Configuration registers never stall; a write is registered at the edge that accepts it.
  assign cfg_ready_o = 1'b1;

  xpbm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // A command beat updates the mapping state at the same edge that its
  // result is captured in the output buffer.
  assign cmd_fire = s_axis_tvalid && s_axis_tready;

  xpbm_map_state u_state (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cmd_fire_i   (cmd_fire),
    .opcode_i     (s_axis_tuser),
    .port_value_i (s_axis_tdata),
    .result_o     (map_result)
  );

  // The skid stage lets a new command in while a result still waits for the
  // consumer; input stalls only once both entries are full.
  xpbm_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (map_result),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_result)
  );

  assign m_axis_tdata = {(OutDataW - ResultW)'(0), out_result};

endmodule

`default_nettype wire

### sim/xpbm_map_checker.sv
// Checker for the PORTB bank mapper: watches the command, result and config channels.
// It keeps its own copy of the mapping state and compares each result beat field by field.
// Depends on xpbm_pkg for the opcode, configuration and result types.
`timescale 1ns / 1ps

module xpbm_map_checker import xpbm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  logic                cmd_ready_i,
  input  logic [PortW-1:0]    cmd_data_i,
  input  logic [OpW-1:0]      cmd_user_i,
  input  logic                res_valid_i,
  input  logic                res_ready_i,
  input  logic [OutDataW-1:0] res_data_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDatW-1:0]  cfg_data_i,
  output int                  pending_o,
  output int                  errors_o
);

  // Configuration as written, before folding of out-of-range codes.
  logic [1:0]       class_reg;
  logic [2:0]       ram_reg;

  // Mapping state.
  logic [PortW-1:0] port_q;
  logic [BankW-1:0] bank_q;
  antic_mode_e      antic_q;
  logic [BankW-1:0] antic_ext_q;
  logic             os_on_q;
  logic             selftest_q;
  logic             cart_lo_q;
  logic             cart_hi_q;
  logic             trig_q;

  xpbm_result_t     maps_due[$];
  xpbm_result_t     want;
  xpbm_result_t     got;
  int               maps_seen;
  int               mismatches;

  assign pending_o = maps_due.size();
  assign errors_o  = mismatches;

  task automatic report(input string msg);
    $display("[%0t] map %0d: %s", $time, maps_seen, msg);
    mismatches++;
  endtask

  function automatic machine_class_e active_class();
    return (class_reg >= 2'd2) ? CLASS_XLXE : machine_class_e'(class_reg);
  endfunction

  function automatic ram_size_e active_ram();
    case (active_class())
      CLASS_800:  return RAM_48K;
      CLASS_5200: return RAM_16K;
      default: begin
        case (ram_reg)
          3'd0:    return RAM_48K;
          3'd1:    return RAM_64K;
          3'd2:    return RAM_128K;
          3'd3:    return RAM_320K;
          3'd4:    return RAM_576K;
          default: return RAM_1M;
        endcase
      end
    endcase
  endfunction

  task automatic write_portb(input logic [PortW-1:0] pb);
    machine_class_e cls;
    ram_size_e      ram;
    int             p;
    int             bank;
    int             idx;
    cls = active_class();
    ram = active_ram();
    p   = int'(pb);
    // The 800 has no PORTB at all: the write is dropped and not even latched.
    if (cls == CLASS_800) return;
    if (ram > RAM_64K) begin
      bank = 0;
      if (!pb[4]) begin
        case (ram)
          RAM_128K: bank = ((p & 'h0c) >> 2) + 1;
          RAM_320K: bank = (((p & 'h0c) + ((p & 'h60) >> 1)) >> 2) + 1;
          RAM_576K: bank = (((p & 'h0e) + ((p & 'hc0) >> 2)) >> 1) + 1;
          default:  bank = (((p & 'h0e) + ((p & 'he0) >> 1)) >> 1) + 1;
        endcase
      end
      if (selftest_q && (bank != int'(bank_q) || (ram == RAM_576K && !pb[5])))
        selftest_q = 1'b0;
      bank_q = bank[BankW-1:0];
      // Only the 128K and 576K schemes give ANTIC its own bank select.
      if (ram == RAM_128K || ram == RAM_576K) begin
        case (pb[5:4])
          2'b10: antic_q = ANTIC_BASE;
          2'b01: begin
            if (ram == RAM_128K)
              idx = (p & 'h0c) >> 2;
            else
              idx = ((p & 'h0e) + ((p & 'hc0) >> 2)) >> 1;
            antic_q     = ANTIC_EXT;
            antic_ext_q = BankW'(idx + 1);
          end
          default: antic_q = ANTIC_SAME;
        endcase
      end
    end
    if (port_q[0] != pb[0]) begin
      os_on_q = pb[0];
      if (!pb[0]) selftest_q = 1'b0;
    end
    if (cls == CLASS_XLXE) begin
      if (pb[7] || (ram == RAM_576K && !pb[5]))
        selftest_q = 1'b0;
      else if (!selftest_q && pb[0] && !(pb[5:4] != 2'b11 && ram == RAM_576K)
               && !(!pb[4] && ram == RAM_1M))
        selftest_q = 1'b1;
    end
    port_q = pb;
  endtask

  // Applies one command and returns the mapping that follows from it.
  task automatic predict_mapping(input logic [OpW-1:0] op, input logic [PortW-1:0] pb,
                                 output xpbm_result_t map);
    ram_size_e ram;
    logic      no_basic;
    case (op)
      OP_PORTB_WR:  write_portb(pb);
      OP_CART8_ON:  cart_lo_q = 1'b1;
      OP_CART8_OFF: cart_lo_q = 1'b0;
      OP_CARTA_ON: begin
        if (!cart_hi_q) begin
          cart_hi_q = 1'b1;
          if (active_class() == CLASS_XLXE) trig_q = 1'b1;
        end
      end
      OP_CARTA_OFF: begin
        if (cart_hi_q) begin
          cart_hi_q = 1'b0;
          if (active_class() == CLASS_XLXE) trig_q = 1'b0;
        end
      end
      default: ;
    endcase
    ram      = active_ram();
    no_basic = port_q[1] || (!port_q[4] && ram >= RAM_576K);
    map              = '0;
    map.cpu_bank     = bank_q;
    map.antic_mode   = antic_q;
    map.antic_bank   = (antic_q == ANTIC_EXT) ? antic_ext_q : BankW'(1);
    map.os_area      = os_on_q ? OS_ROM : ((ram > RAM_48K) ? OS_RAM : OS_OPENBUS);
    if (cart_hi_q)
      map.a000_area = A000_CART;
    else if (active_class() == CLASS_XLXE && !no_basic)
      map.a000_area = A000_BASIC;
    else
      map.a000_area = A000_RAM;
    map.selftest_on  = selftest_q;
    map.cart_8000_on = cart_lo_q;
    map.trig_three   = trig_q;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      class_reg   = CLASS_XLXE;
      ram_reg     = 3'd1;
      port_q      = 8'hff;
      bank_q      = '0;
      antic_q     = ANTIC_SAME;
      antic_ext_q = BankW'(1);
      os_on_q     = 1'b1;
      selftest_q  = 1'b0;
      cart_lo_q   = 1'b0;
      cart_hi_q   = 1'b0;
      trig_q      = 1'b0;
      maps_due.delete();
      maps_seen   = 0;
      mismatches  = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_MACHINE_CLASS: class_reg = cfg_data_i[1:0];
          CFG_RAM_KIND:      ram_reg   = cfg_data_i[2:0];
          default: ;
        endcase
      end
      // Results first: a result beat can never belong to a command taken at the same edge.
      if (res_valid_i && res_ready_i) begin
        if (maps_due.size() == 0) begin
          report($sformatf("result beat 0x%06h with no command outstanding", res_data_i));
        end else begin
          want = maps_due.pop_front();
          got  = xpbm_result_t'(res_data_i[ResultW-1:0]);
          if (got.cpu_bank !== want.cpu_bank)
            report($sformatf("cpu_bank got %0d, expected %0d", got.cpu_bank, want.cpu_bank));
          if (got.antic_mode !== want.antic_mode)
            report($sformatf("antic_mode got %0d, expected %0d",
                             got.antic_mode, want.antic_mode));
          if (got.antic_bank !== want.antic_bank)
            report($sformatf("antic_bank got %0d, expected %0d",
                             got.antic_bank, want.antic_bank));
          if (got.os_area !== want.os_area)
            report($sformatf("os_area got %0d, expected %0d", got.os_area, want.os_area));
          if (got.a000_area !== want.a000_area)
            report($sformatf("a000_area got %0d, expected %0d",
                             got.a000_area, want.a000_area));
          if (got.selftest_on !== want.selftest_on)
            report($sformatf("selftest_on got %0b, expected %0b",
                             got.selftest_on, want.selftest_on));
          if (got.cart_8000_on !== want.cart_8000_on)
            report($sformatf("cart_8000_on got %0b, expected %0b",
                             got.cart_8000_on, want.cart_8000_on));
          if (got.trig_three !== want.trig_three)
            report($sformatf("trig_three got %0b, expected %0b",
                             got.trig_three, want.trig_three));
          if (res_data_i[OutDataW-1:ResultW] !== '0)
            report($sformatf("pad bits got %0b, expected zero",
                             res_data_i[OutDataW-1:ResultW]));
        end
        maps_seen++;
      end
      if (cmd_valid_i && cmd_ready_i) begin
        predict_mapping(cmd_user_i, cmd_data_i, want);
        maps_due.push_back(want);
      end
    end
  end

endmodule

### sim/xe_portb_bank_mapper_test.sv
// Testbench top for xe_portb_bank_mapper: clock, reset, command and config stimulus, verdict.
// Instantiates the mapper as u_top and xpbm_map_checker beside it; imports xpbm_pkg.
`timescale 1ns / 1ps

module xe_portb_bank_mapper_test;
  import xpbm_pkg::*;

  localparam int CycleLimit   = 200000;
  localparam int SettleCycles = 4;    // idle cycles after the last result before a config write
  localparam int PhaseItems   = 60;
  localparam int NumPhases    = 13;

  // Configuration walked through by the random phases: class 0..3 and RAM kind 0..7,
  // so both ends of each register and the folded codes are all visited.
  localparam logic [0:NumPhases-1][1:0] PhaseClass =
    {2'd2, 2'd2, 2'd0, 2'd2, 2'd1, 2'd2, 2'd3, 2'd2, 2'd2, 2'd1, 2'd2, 2'd0, 2'd2};
  localparam logic [0:NumPhases-1][2:0] PhaseRam =
    {3'd1, 3'd5, 3'd3, 3'd2, 3'd4, 3'd3, 3'd4, 3'd0, 3'd7, 3'd0, 3'd6, 3'd0, 3'd4};

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [PortW-1:0]    s_axis_tdata  = '0;   // [7:0] port_value
  logic [OpW-1:0]      s_axis_tuser  = '0;   // [2:0] opcode
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b1;
  // [6:0] cpu_bank, [8:7] antic_mode, [15:9] antic_bank, [17:16] os_area,
  // [19:18] a000_area, [20] selftest_on, [21] cart_8000_on, [22] trig_three, [23] zero
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [CfgDatW-1:0]  cfg_data_i    = '0;

  int pending_maps;
  int map_errors;
  int cycle_cnt  = 0;
  int burst_left = 0;
  int stall_left = 0;
  int stall_mode = 0;

  xe_portb_bank_mapper u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  xpbm_map_checker u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (s_axis_tvalid),
    .cmd_ready_i (s_axis_tready),
    .cmd_data_i  (s_axis_tdata),
    .cmd_user_i  (s_axis_tuser),
    .res_valid_i (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_data_i  (m_axis_tdata),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pending_o   (pending_maps),
    .errors_o    (map_errors)
  );

  always #4 clk_i = ~clk_i;

  // The receiver switches at random intervals between always ready, coin-flip ready,
  // mostly stalled and a fixed on/off rhythm set by the cycle counter, so stalls land on
  // every phase of the command stream and there are long stall-free stretches too.
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(16, 96);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= 1'($urandom_range(0, 1));
      2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= ((cycle_cnt % 5) < 3);
    endcase
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Sends one command beat. The sender runs in bursts; only between bursts does
  // tvalid drop, so a beat that follows directly keeps tvalid high throughout.
  task automatic send_cmd(input logic [OpW-1:0] op, input logic [PortW-1:0] pb);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pb;
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Holds the sender off until every outstanding result has been taken, then lets
  // the pipeline settle. The count is sampled at the falling edge to stay clear of
  // the checker's updates at the rising edge.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(negedge clk_i);
    while (pending_maps != 0) @(negedge clk_i);
    @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Writes both registers back to back; valid stays high between the two beats.
  task automatic set_config(input logic [1:0] cls, input logic [2:0] ram);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_MACHINE_CLASS;
    cfg_data_i  <= CfgDatW'(cls);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_index_i <= CFG_RAM_KIND;
    cfg_data_i  <= CfgDatW'(ram);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    logic [OpW-1:0]   op;
    logic [PortW-1:0] pb;
    int               pick;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part on the reset setting (XL/XE, 64K): OS ROM off and on again,
    // BASIC in and out, self-test enable and its clearing by bit 7, repeated
    // cartridge switching, and the opcodes beyond the defined set.
    send_cmd(OP_PORTB_WR, 8'hff);
    send_cmd(OP_PORTB_WR, 8'h00);
    send_cmd(OP_PORTB_WR, 8'h01);
    send_cmd(OP_PORTB_WR, 8'h7d);
    send_cmd(OP_PORTB_WR, 8'hfd);
    send_cmd(OP_PORTB_WR, 8'h7c);
    send_cmd(OP_CART8_ON, 8'h00);
    send_cmd(OP_CART8_ON, 8'hff);
    send_cmd(OP_CART8_OFF, 8'h00);
    send_cmd(OP_CART8_OFF, 8'h00);
    send_cmd(OP_CARTA_ON, 8'h00);
    send_cmd(OP_CARTA_ON, 8'h00);
    send_cmd(OP_CARTA_OFF, 8'h00);
    send_cmd(OP_CARTA_OFF, 8'h00);
    send_cmd(3'd5, 8'haa);
    send_cmd(3'd6, 8'h55);
    send_cmd(3'd7, 8'hff);

    // Directed bank picks on 1088K: lowest and highest extended bank, then base RAM.
    set_config(CLASS_XLXE, 3'd5);
    send_cmd(OP_PORTB_WR, 8'h01);
    send_cmd(OP_PORTB_WR, 8'hef);
    send_cmd(OP_PORTB_WR, 8'h7f);
    send_cmd(OP_PORTB_WR, 8'hff);

    // Random phases, one per configuration setting.
    for (int ph = 0; ph < NumPhases; ph++) begin
      set_config(PhaseClass[ph], PhaseRam[ph]);
      for (int n = 0; n < PhaseItems; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 60)
          op = OP_PORTB_WR;
        else if (pick < 95)
          op = OpW'($urandom_range(1, 4));
        else
          op = OpW'($urandom_range(5, 7));
        pb = PortW'($urandom_range(0, 255));
        // Bias toward values that enable self-test, and toward extended bank picks.
        if ($urandom_range(0, 3) == 0) pb = (pb & 8'h4e) | 8'h31;
        if ($urandom_range(0, 3) == 0) pb[4] = 1'b0;
        send_cmd(op, pb);
        // Hold off mid-phase now and then until the result stream is empty.
        if (n == PhaseItems / 2 && ph % 4 == 1) drain();
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (map_errors == 0 && pending_maps == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

### xe_portb_bank_mapper.f
rtl/xpbm_pkg.sv
rtl/xpbm_cfg_regs.sv
rtl/xpbm_map_state.sv
rtl/xpbm_out_buf.sv
rtl/xe_portb_bank_mapper.sv
sim/xpbm_map_checker.sv
sim/xe_portb_bank_mapper_test.sv
